FILE: hw/rtl/blh_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the line-drawing pixel histogram
// no dependencies

package blh_pkg;

   // request opcodes
   localparam logic OP_DRAW = 1'b0;
   localparam logic OP_READ = 1'b1;

   // channel code that walks the line but counts nothing
   localparam logic [1:0] CHAN_NONE = 2'd3;
   localparam int NUM_CHAN = 3;

   // field widths fixed by the interface
   localparam int COUNT_W   = 32;
   localparam int HITS_W    = 17;
   localparam int RD_ADDR_W = 16;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam int RESET_DIM = 256;

   // front queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef struct packed {
      logic       opcode;
      logic [1:0] channel;
      logic       sx_neg;
      logic       sy_neg;
   } cmd_ctl_type;

   typedef enum logic [2:0] {
      BK_CLEAR = 3'd0,
      BK_IDLE  = 3'd1,
      BK_DRAW  = 3'd2,
      BK_DRAIN = 3'd3,
      BK_READ  = 3'd4
   } back_state_type;

endpackage

FILE: hw/rtl/blh_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies

module blh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/blh_front.sv
`timescale 1ns / 1ps
// front part: accepts requests, works out line spans and step directions,
// and holds them in a two-entry queue; uses blh_pkg

module blh_front #(
   parameter int COORD_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   output logic                                  full,
   input  logic                                  req_opcode,
   input  logic signed [COORD_BITS-1:0]          req_start_x,
   input  logic signed [COORD_BITS-1:0]          req_start_y,
   input  logic signed [COORD_BITS-1:0]          req_end_x,
   input  logic signed [COORD_BITS-1:0]          req_end_y,
   input  logic [1:0]                            req_channel,
   input  logic [blh_pkg::RD_ADDR_W-1:0]         req_read_address,
   input  logic                                  clear_busy,
   output logic                                  cmd_valid,
   input  logic                                  cmd_pop,
   output blh_pkg::cmd_ctl_type                  cmd_ctl,
   output logic [COORD_BITS-1:0]                 cmd_x0,
   output logic [COORD_BITS-1:0]                 cmd_y0,
   output logic [COORD_BITS-1:0]                 cmd_x1,
   output logic [COORD_BITS-1:0]                 cmd_y1,
   output logic [COORD_BITS-1:0]                 cmd_dx,
   output logic [COORD_BITS-1:0]                 cmd_dy,
   output logic [blh_pkg::RD_ADDR_W-1:0]         cmd_addr
);

   import blh_pkg::*;

   cmd_ctl_type           q_ctl_ff  [QUEUE_DEPTH];
   logic [COORD_BITS-1:0] q_x0_ff   [QUEUE_DEPTH];
   logic [COORD_BITS-1:0] q_y0_ff   [QUEUE_DEPTH];
   logic [COORD_BITS-1:0] q_x1_ff   [QUEUE_DEPTH];
   logic [COORD_BITS-1:0] q_y1_ff   [QUEUE_DEPTH];
   logic [COORD_BITS-1:0] q_dx_ff   [QUEUE_DEPTH];
   logic [COORD_BITS-1:0] q_dy_ff   [QUEUE_DEPTH];
   logic [RD_ADDR_W-1:0]  q_addr_ff [QUEUE_DEPTH];

   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   logic                  push_acc;
   logic [COORD_BITS:0]   diff_x, diff_y, abs_x, abs_y;
   cmd_ctl_type           ent_ctl_in;
   logic [COORD_BITS-1:0] ent_dx_in, ent_dy_in;

   // signed spans and their magnitudes
   always_comb begin
      diff_x = {req_end_x[COORD_BITS-1], req_end_x} - {req_start_x[COORD_BITS-1], req_start_x};
      diff_y = {req_end_y[COORD_BITS-1], req_end_y} - {req_start_y[COORD_BITS-1], req_start_y};
      abs_x  = diff_x[COORD_BITS] ? (~diff_x + (COORD_BITS+1)'(1)) : diff_x;
      abs_y  = diff_y[COORD_BITS] ? (~diff_y + (COORD_BITS+1)'(1)) : diff_y;
      ent_dx_in = abs_x[COORD_BITS-1:0];
      ent_dy_in = abs_y[COORD_BITS-1:0];
      ent_ctl_in.opcode  = req_opcode;
      ent_ctl_in.channel = req_channel;
      // step goes negative unless the end lies strictly beyond the start
      ent_ctl_in.sx_neg  = diff_x[COORD_BITS] || (diff_x == '0);
      ent_ctl_in.sy_neg  = diff_y[COORD_BITS] || (diff_y == '0);
   end

   assign full      = (cnt_ff == QCNT_W'(QUEUE_DEPTH)) || clear_busy;
   assign push_acc  = push && !full;
   assign cmd_valid = (cnt_ff != '0);

   always_comb begin
      wr_ptr_in = push_acc ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(push_acc) - QCNT_W'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_acc) begin
         q_ctl_ff[wr_ptr_ff]  <= ent_ctl_in;
         q_x0_ff[wr_ptr_ff]   <= req_start_x;
         q_y0_ff[wr_ptr_ff]   <= req_start_y;
         q_x1_ff[wr_ptr_ff]   <= req_end_x;
         q_y1_ff[wr_ptr_ff]   <= req_end_y;
         q_dx_ff[wr_ptr_ff]   <= ent_dx_in;
         q_dy_ff[wr_ptr_ff]   <= ent_dy_in;
         q_addr_ff[wr_ptr_ff] <= req_read_address;
      end
   end

   assign cmd_ctl  = q_ctl_ff[rd_ptr_ff];
   assign cmd_x0   = q_x0_ff[rd_ptr_ff];
   assign cmd_y0   = q_y0_ff[rd_ptr_ff];
   assign cmd_x1   = q_x1_ff[rd_ptr_ff];
   assign cmd_y1   = q_y1_ff[rd_ptr_ff];
   assign cmd_dx   = q_dx_ff[rd_ptr_ff];
   assign cmd_dy   = q_dy_ff[rd_ptr_ff];
   assign cmd_addr = q_addr_ff[rd_ptr_ff];

`ifndef SYNTH
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (cnt_ff != '0))
      else $error("front queue popped while empty");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (push_acc && !cmd_pop) |=> (cnt_ff == $past(cnt_ff) + QCNT_W'(1)))
      else $error("front queue lost a request");
`endif

endmodule

FILE: hw/rtl/blh_back.sv
`timescale 1ns / 1ps
// back part: clearing pass, line walker with read-modify-write of the
// counter rams, pixel reads and the result slot; uses blh_pkg and blh_ram

module blh_back #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int COORD_BITS = 16,
   localparam int WW = $clog2(MAX_WIDTH + 1),
   localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  cmd_valid,
   output logic                                  cmd_pop,
   input  blh_pkg::cmd_ctl_type                  cmd_ctl,
   input  logic [COORD_BITS-1:0]                 cmd_x0,
   input  logic [COORD_BITS-1:0]                 cmd_y0,
   input  logic [COORD_BITS-1:0]                 cmd_x1,
   input  logic [COORD_BITS-1:0]                 cmd_y1,
   input  logic [COORD_BITS-1:0]                 cmd_dx,
   input  logic [COORD_BITS-1:0]                 cmd_dy,
   input  logic [blh_pkg::RD_ADDR_W-1:0]         cmd_addr,
   input  logic [WW-1:0]                         width_eff,
   input  logic [HW-1:0]                         height_eff,
   output logic                                  clear_busy,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic [blh_pkg::COUNT_W-1:0]           rsp_count_first,
   output logic [blh_pkg::COUNT_W-1:0]           rsp_count_second,
   output logic [blh_pkg::COUNT_W-1:0]           rsp_count_third,
   output logic [blh_pkg::HITS_W-1:0]            rsp_pixels_hit
);

   import blh_pkg::*;

   localparam int HIST_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W     = $clog2(HIST_DEPTH);
   localparam int ERR_W      = COORD_BITS + 2;
   localparam int LW0        = (COORD_BITS > WW) ? COORD_BITS : WW;
   localparam int LW         = (LW0 > HW) ? LW0 : HW;

   back_state_type state_ff, state_in;

   logic [ADDR_W-1:0]       clear_cnt_ff, clear_cnt_in;
   logic [COORD_BITS-1:0]   x_ff, x_in, y_ff, y_in;
   logic [COORD_BITS-1:0]   x_end_ff, x_end_in, y_end_ff, y_end_in;
   logic [COORD_BITS-1:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic                    sx_neg_ff, sx_neg_in, sy_neg_ff, sy_neg_in;
   logic [1:0]              chan_ff, chan_in;
   logic [HITS_W-1:0]       hits_ff, hits_in;
   logic                    wr_valid_ff, wr_valid_in;
   logic [ADDR_W-1:0]       wr_addr_ff, wr_addr_in;
   logic [1:0]              wr_chan_ff, wr_chan_in;
   logic                    rd_in_range_ff, rd_in_range_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]      rsp_first_ff, rsp_first_in;
   logic [COUNT_W-1:0]      rsp_second_ff, rsp_second_in;
   logic [COUNT_W-1:0]      rsp_third_ff, rsp_third_in;
   logic [HITS_W-1:0]       rsp_hits_ff, rsp_hits_in;

   // fsm outputs
   logic clearing, load_walk, load_read, walking, rsp_load_draw, rsp_load_read;

   logic                    slot_free, clear_last, at_end, hit, step_x, step_y;
   logic signed [ERR_W-1:0] dx_s, dy_s, err_init;
   logic [ADDR_W-1:0]       pix_addr, ram_raddr, ram_waddr;
   logic                    ram_we    [NUM_CHAN];
   logic [COUNT_W-1:0]      ram_wdata [NUM_CHAN];
   logic [COUNT_W-1:0]      ram_rdata [NUM_CHAN];

   assign slot_free  = !rsp_valid_ff || rsp_pop;
   assign clear_last = (clear_cnt_ff == ADDR_W'(HIST_DEPTH - 1));
   assign at_end     = (x_ff == x_end_ff) && (y_ff == y_end_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CLEAR: if (clear_last) state_in = BK_IDLE;
         BK_IDLE: begin
            if (cmd_valid && slot_free) begin
               state_in = (cmd_ctl.opcode == OP_READ) ? BK_READ : BK_DRAW;
            end
         end
         BK_DRAW:  if (at_end) state_in = BK_DRAIN;
         BK_DRAIN: state_in = BK_IDLE;
         BK_READ:  state_in = BK_IDLE;
         default:  state_in = BK_CLEAR;
      endcase
   end

   // fsm outputs
   always_comb begin
      clearing      = 1'b0;
      cmd_pop       = 1'b0;
      load_walk     = 1'b0;
      load_read     = 1'b0;
      walking       = 1'b0;
      rsp_load_draw = 1'b0;
      rsp_load_read = 1'b0;
      unique case (state_ff)
         BK_CLEAR: clearing = 1'b1;
         BK_IDLE: begin
            cmd_pop   = cmd_valid && slot_free;
            load_walk = cmd_valid && slot_free && (cmd_ctl.opcode == OP_DRAW);
            load_read = cmd_valid && slot_free && (cmd_ctl.opcode == OP_READ);
         end
         BK_DRAW:  walking = 1'b1;
         BK_DRAIN: rsp_load_draw = 1'b1;
         BK_READ:  rsp_load_read = 1'b1;
         default:  clearing = 1'b0;
      endcase
   end

   assign clear_busy = clearing;

   // pixel test and address of the current walker position
   always_comb begin
      hit = !x_ff[COORD_BITS-1] && (x_ff != '0) && (LW'(x_ff) < LW'(width_eff))
         && !y_ff[COORD_BITS-1] && (y_ff != '0) && (LW'(y_ff) < LW'(height_eff))
         && (chan_ff != CHAN_NONE);
      pix_addr = ADDR_W'(x_ff) + ADDR_W'(ADDR_W'(y_ff) * ADDR_W'(width_eff));
   end

   // error term and step decisions
   always_comb begin
      dx_s     = $signed(ERR_W'(dx_ff));
      dy_s     = $signed(ERR_W'(dy_ff));
      step_x   = err_ff > -dx_s;
      step_y   = err_ff < dy_s;
      err_init = (cmd_dx > cmd_dy) ? $signed(ERR_W'(cmd_dx >> 1))
                                   : -$signed(ERR_W'(cmd_dy >> 1));
   end

   // walker datapath
   always_comb begin
      clear_cnt_in = clearing ? clear_cnt_ff + ADDR_W'(1) : clear_cnt_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      x_end_in  = x_end_ff;
      y_end_in  = y_end_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      err_in    = err_ff;
      sx_neg_in = sx_neg_ff;
      sy_neg_in = sy_neg_ff;
      chan_in   = chan_ff;
      hits_in   = hits_ff;
      if (load_walk) begin
         x_in      = cmd_x0;
         y_in      = cmd_y0;
         x_end_in  = cmd_x1;
         y_end_in  = cmd_y1;
         dx_in     = cmd_dx;
         dy_in     = cmd_dy;
         err_in    = err_init;
         sx_neg_in = cmd_ctl.sx_neg;
         sy_neg_in = cmd_ctl.sy_neg;
         chan_in   = cmd_ctl.channel;
         hits_in   = '0;
      end else if (walking) begin
         hits_in = hits_ff + HITS_W'(hit);
         if (!at_end) begin
            err_in = err_ff - (step_x ? dy_s : ERR_W'(0)) + (step_y ? dx_s : ERR_W'(0));
            if (step_x) begin
               x_in = sx_neg_ff ? x_ff - COORD_BITS'(1) : x_ff + COORD_BITS'(1);
            end
            if (step_y) begin
               y_in = sy_neg_ff ? y_ff - COORD_BITS'(1) : y_ff + COORD_BITS'(1);
            end
         end
      end
      wr_valid_in    = walking && hit;
      wr_addr_in     = pix_addr;
      wr_chan_in     = chan_ff;
      rd_in_range_in = load_read ? (32'(cmd_addr) < 32'(HIST_DEPTH)) : rd_in_range_ff;
   end

   // result slot
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_third_in  = rsp_third_ff;
      rsp_hits_in   = rsp_hits_ff;
      if (rsp_load_draw) begin
         rsp_valid_in  = 1'b1;
         rsp_first_in  = '0;
         rsp_second_in = '0;
         rsp_third_in  = '0;
         rsp_hits_in   = hits_ff;
      end else if (rsp_load_read) begin
         rsp_valid_in  = 1'b1;
         rsp_first_in  = rd_in_range_ff ? ram_rdata[0] : '0;
         rsp_second_in = rd_in_range_ff ? ram_rdata[1] : '0;
         rsp_third_in  = rd_in_range_ff ? ram_rdata[2] : '0;
         rsp_hits_in   = '0;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clear_cnt_ff <= '0;
         wr_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         wr_valid_ff  <= wr_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff           <= x_in;
      y_ff           <= y_in;
      x_end_ff       <= x_end_in;
      y_end_ff       <= y_end_in;
      dx_ff          <= dx_in;
      dy_ff          <= dy_in;
      err_ff         <= err_in;
      sx_neg_ff      <= sx_neg_in;
      sy_neg_ff      <= sy_neg_in;
      chan_ff        <= chan_in;
      hits_ff        <= hits_in;
      wr_addr_ff     <= wr_addr_in;
      wr_chan_ff     <= wr_chan_in;
      rd_in_range_ff <= rd_in_range_in;
      rsp_first_ff   <= rsp_first_in;
      rsp_second_ff  <= rsp_second_in;
      rsp_third_ff   <= rsp_third_in;
      rsp_hits_ff    <= rsp_hits_in;
   end

   // counter rams: read at the walker pixel or the read address,
   // write back in the following cycle with the incremented count
   assign ram_raddr = walking ? pix_addr : ADDR_W'(cmd_addr);
   assign ram_waddr = clearing ? clear_cnt_ff : wr_addr_ff;

   for (genvar i = 0; i < NUM_CHAN; i++) begin : g_bank
      assign ram_we[i]    = clearing || (wr_valid_ff && (wr_chan_ff == 2'(i)));
      assign ram_wdata[i] = clearing ? '0 : ram_rdata[i] + COUNT_W'(1);

      blh_ram #(
         .WIDTH (COUNT_W),
         .DEPTH (HIST_DEPTH)
      ) u_ram (
         .clock (clock),
         .we    (ram_we[i]),
         .waddr (ram_waddr),
         .wdata (ram_wdata[i]),
         .raddr (ram_raddr),
         .rdata (ram_rdata[i])
      );
   end

   assign rsp_empty        = !rsp_valid_ff;
   assign rsp_count_first  = rsp_first_ff;
   assign rsp_count_second = rsp_second_ff;
   assign rsp_count_third  = rsp_third_ff;
   assign rsp_pixels_hit   = rsp_hits_ff;

`ifndef SYNTH
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_IDLE) |-> !wr_valid_ff)
      else $error("write-back still pending when a new request may start");

   a_slot_free_on_finish: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == BK_DRAIN) || (state_ff == BK_READ)) |-> !rsp_valid_ff)
      else $error("result slot occupied when a request finishes");

   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> (!cmd_pop && !wr_valid_ff))
      else $error("request handled during clearing pass");
`endif

endmodule

FILE: hw/rtl/bresenham_line_histogram.sv
`timescale 1ns / 1ps
// line-drawing pixel histogram: top level with configuration registers
// depends on blh_pkg, blh_front, blh_back, blh_ram
//
// usage
//  - requests enter through a queue-style port: a request is taken at a clock
//    edge with push high and full low. opcode 0 draws a line from the start to
//    the end point and adds one to the chosen channel's counter at every pixel
//    with 0 < x < width and 0 < y < height; opcode 1 reads the three counters
//    at read_address.
//  - results leave the same way: the oldest result sits on the rsp_ ports
//    while empty is low and is taken at an edge with pop high.
//  - a draw occupies the line walker for every visited pixel plus start and
//    write-back drain; a read passes through its own read state.
//    the rate is set by the walker, which does one counter read-modify-write
//    per cycle through the ram read and write ports.
//  - after reset a clearing pass writes zero to every counter, one address a
//    cycle, MAX_WIDTH*MAX_HEIGHT addresses (65536 by default); full stays high
//    meanwhile. configuration writes are taken at any time (csr_ready is high)
//    and must only be issued while the block is idle.
//  - a two-entry queue sits between intake and walker; with the result slot
//    stalled by the receiver, the walker waits and the queue fills, then full
//    rises.

module bresenham_line_histogram #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int COORD_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  push,
   output logic                                  full,
   input  logic                                  req_opcode,
   input  logic signed [COORD_BITS-1:0]          req_start_x,
   input  logic signed [COORD_BITS-1:0]          req_start_y,
   input  logic signed [COORD_BITS-1:0]          req_end_x,
   input  logic signed [COORD_BITS-1:0]          req_end_y,
   input  logic [1:0]                            req_channel,
   input  logic [blh_pkg::RD_ADDR_W-1:0]         req_read_address,
   // result channel
   output logic                                  empty,
   input  logic                                  pop,
   output logic [blh_pkg::COUNT_W-1:0]           rsp_count_first,
   output logic [blh_pkg::COUNT_W-1:0]           rsp_count_second,
   output logic [blh_pkg::COUNT_W-1:0]           rsp_count_third,
   output logic [blh_pkg::HITS_W-1:0]            rsp_pixels_hit,
   // configuration write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [blh_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [blh_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   import blh_pkg::*;

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   // reset dimensions, clamped to what the histogram holds
   localparam int RESET_W = (RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : RESET_DIM;
   localparam int RESET_H = (RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : RESET_DIM;

   // the registers keep only the clamped dimension; larger values act as max
   logic [WW-1:0] width_ff, width_in;
   logic [HW-1:0] height_ff, height_in;
   logic          csr_write;

   // front to back
   logic                  clear_busy, cmd_valid, cmd_pop;
   cmd_ctl_type           cmd_ctl;
   logic [COORD_BITS-1:0] cmd_x0, cmd_y0, cmd_x1, cmd_y1, cmd_dx, cmd_dy;
   logic [RD_ADDR_W-1:0]  cmd_addr;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // register decode; unknown indexes are dropped
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_in = (32'(csr_wdata) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(csr_wdata);
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = (32'(csr_wdata) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(csr_wdata);
            end
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WW'(RESET_W);
         height_ff <= HW'(RESET_H);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // intake, span computation and two-entry queue
   blh_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_opcode       (req_opcode),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .req_channel      (req_channel),
      .req_read_address (req_read_address),
      .clear_busy       (clear_busy),
      .cmd_valid        (cmd_valid),
      .cmd_pop          (cmd_pop),
      .cmd_ctl          (cmd_ctl),
      .cmd_x0           (cmd_x0),
      .cmd_y0           (cmd_y0),
      .cmd_x1           (cmd_x1),
      .cmd_y1           (cmd_y1),
      .cmd_dx           (cmd_dx),
      .cmd_dy           (cmd_dy),
      .cmd_addr         (cmd_addr)
   );

   // line walker, counter rams and result slot
   blh_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd_pop          (cmd_pop),
      .cmd_ctl          (cmd_ctl),
      .cmd_x0           (cmd_x0),
      .cmd_y0           (cmd_y0),
      .cmd_x1           (cmd_x1),
      .cmd_y1           (cmd_y1),
      .cmd_dx           (cmd_dx),
      .cmd_dy           (cmd_dy),
      .cmd_addr         (cmd_addr),
      .width_eff        (width_ff),
      .height_eff       (height_ff),
      .clear_busy       (clear_busy),
      .rsp_empty        (empty),
      .rsp_pop          (pop),
      .rsp_count_first  (rsp_count_first),
      .rsp_count_second (rsp_count_second),
      .rsp_count_third  (rsp_count_third),
      .rsp_pixels_hit   (rsp_pixels_hit)
   );

endmodule
